/* rtl/shp_pkg.sv */
package shp_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam int NSUM_W    = PIX_W + 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EIGHTHS = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd80;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd60;
    localparam logic [CFG_W-1:0] GAIN_EIGHTHS_RST = 8'd32;

    localparam int MIN_DIM = 3;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } shp_meta_t;

endpackage

/* rtl/shp_pix_if.sv */
interface shp_pix_if;
    import shp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

/* rtl/shp_res_if.sv */
interface shp_res_if;
    import shp_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   sharp_pixel;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_end;

    modport source (output valid, output sharp_pixel, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink (input valid, input sharp_pixel, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

/* rtl/shp_cfg_if.sv */
interface shp_cfg_if;
    import shp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/sharpen_3x3_filter_core.sv */
// channel   dir  word                                           handshake
// cfg       in   index, data                                    valid/ready, ready always high
// pixels    in   pixel_in, frame_start                          valid/ready
// results   out  sharp_pixel, out_row, out_col, frame_end       valid/ready
//
// one pixel word accepted per cycle while the results channel does not stall; a result
// leaves its closing pixel through line store read, product stage and output register
// the line stores are single synchronous memories, read on accept and written
// as the word leaves the window stage; a same-column rewrite is forwarded from the write stage
// reset clears counters, window and valids; line stores need no clearing pass
// a stalled results channel holds the pipeline back and drops pixels.ready
module sharpen_3x3_filter_core #(
    parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = shp_pkg::MAX_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    shp_cfg_if.sink   cfg,
    shp_pix_if.sink   pixels,
    shp_res_if.source results
);
    import shp_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = (CW > CFG_W) ? CW : CFG_W;
    localparam int HCW = (RW > CFG_W) ? RW : CFG_W;

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] gain_eighths_reg;

    logic [WCW-1:0]   fw_ext;
    logic [HCW-1:0]   fh_ext;
    logic [CW-1:0]    wid;
    logic [RW-1:0]    hgt;

    // position
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_s;
    logic [RW-1:0]    row_s;
    logic [CW-1:0]    col_p;
    logic [RW-1:0]    row_p;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_next;
    logic [AW-1:0]    rd_addr;
    logic             emit;
    shp_meta_t        meta;

    // line stores
    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    // window stage
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [AW-1:0]    s1_addr_reg;
    shp_meta_t        s1_meta_reg;
    logic [PIX_W-1:0] win_reg [6];

    logic             accept;
    logic             s1_adv;
    logic             k_ready;
    logic [PIX_W-1:0] top_eff;
    logic [PIX_W-1:0] mid_eff;
    logic [NSUM_W-1:0] nsum;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            gain_eighths_reg <= GAIN_EIGHTHS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                REG_GAIN_EIGHTHS: gain_eighths_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign fw_ext = WCW'(frame_width_reg);
    assign fh_ext = HCW'(frame_height_reg);

    always_comb
    begin
        if (fw_ext < WCW'(MIN_DIM))
        begin
            wid = CW'(MIN_DIM);
        end
        else if (fw_ext > WCW'(MAX_WIDTH))
        begin
            wid = CW'(MAX_WIDTH);
        end
        else
        begin
            wid = CW'(fw_ext);
        end
        if (fh_ext < HCW'(MIN_DIM))
        begin
            hgt = RW'(MIN_DIM);
        end
        else if (fh_ext > HCW'(MAX_HEIGHT))
        begin
            hgt = RW'(MAX_HEIGHT);
        end
        else
        begin
            hgt = RW'(fh_ext);
        end
    end

    // position of the incoming word, and where the next one lands
    always_comb
    begin
        col_s = pixels.frame_start ? '0 : col_reg;
        row_s = pixels.frame_start ? '0 : row_reg;
        col_p = col_s;
        row_p = row_s;
        // geometry may have shrunk since the last word
        if (col_s >= wid)
        begin
            col_p = '0;
            row_p = row_s + RW'(1);
        end
        if (row_p >= hgt)
        begin
            row_p = '0;
        end
        col_next = col_p + CW'(1);
        row_next = row_p;
        if (col_next >= wid)
        begin
            col_next = '0;
            row_next = row_p + RW'(1);
        end
        if (row_next >= hgt)
        begin
            row_next = '0;
        end
    end

    assign rd_addr        = col_p[AW-1:0];
    assign emit           = (row_p >= RW'(2)) && (col_p >= CW'(2));
    assign meta.row       = COORD_W'(row_p - RW'(1));
    assign meta.col       = COORD_W'(col_p - CW'(1));
    assign meta.frame_end = (row_p == hgt - RW'(1)) && (col_p == wid - CW'(1));

    assign s1_adv        = s1_valid_reg && (!s1_emit_reg || k_ready);
    assign pixels.ready  = !s1_valid_reg || s1_adv;
    assign accept        = pixels.valid && pixels.ready;

    assign top_eff = fwd_reg ? fwd_top_reg : top_rd_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (s1_addr_reg == rd_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // read before write: an overlap with the same column goes through fwd
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_addr_reg] <= mid_eff;
            lower_mem[s1_addr_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            top_rd_reg <= upper_mem[rd_addr];
            mid_rd_reg <= lower_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixels.pixel_in;
            s1_addr_reg <= rd_addr;
            s1_emit_reg <= emit;
            s1_meta_reg <= meta;
            fwd_top_reg <= mid_eff;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_eff;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_eff;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pix_reg;
        end
    end

    assign nsum = NSUM_W'(win_reg[0]) + NSUM_W'(win_reg[1]) + NSUM_W'(top_eff)
                + NSUM_W'(win_reg[2]) + NSUM_W'(mid_eff)
                + NSUM_W'(win_reg[4]) + NSUM_W'(win_reg[5]) + NSUM_W'(s1_pix_reg);

    shp_kernel u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg && s1_emit_reg),
        .in_ready (k_ready),
        .centre   (win_reg[3]),
        .nsum     (nsum),
        .gain     (gain_eighths_reg),
        .meta     (s1_meta_reg),
        .results  (results)
    );

endmodule

/* rtl/shp_kernel.sv */
module shp_kernel (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [shp_pkg::PIX_W-1:0]  centre,
    input  logic [shp_pkg::NSUM_W-1:0] nsum,
    input  logic [shp_pkg::CFG_W-1:0]  gain,
    input  shp_pkg::shp_meta_t         meta,
    shp_res_if.source                  results
);
    import shp_pkg::*;

    localparam int POS_W = CFG_W + 1 + PIX_W + 3;
    localparam int NEG_W = CFG_W + NSUM_W;
    localparam int DIF_W = POS_W + 1;

    logic              sa_valid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [NEG_W-1:0]  neg_reg;
    shp_meta_t         sa_meta_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    shp_meta_t         out_meta_reg;

    logic              out_free;
    logic              sa_adv;
    logic              in_take;
    logic [CFG_W:0]    gain_plus;
    logic [POS_W-1:0]  pos_next;
    logic [NEG_W-1:0]  neg_next;
    logic [DIF_W-1:0]  diff;
    logic [PIX_W-1:0]  pix_next;

    assign out_free = !out_valid_reg || results.ready;
    assign sa_adv   = sa_valid_reg && out_free;
    assign in_ready = !sa_valid_reg || sa_adv;
    assign in_take  = in_valid && in_ready;

    // acc = 8*(g+8)*centre - g*nsum, in 1/64 units
    assign gain_plus = {1'b0, gain} + (CFG_W+1)'(8);
    assign pos_next  = {(CFG_W+1+PIX_W)'(gain_plus * centre), 3'b000};
    assign neg_next  = NEG_W'(gain * nsum);

    assign diff = {1'b0, pos_reg} - {{(DIF_W-NEG_W){1'b0}}, neg_reg};

    always_comb
    begin
        if (diff[DIF_W-1])
        begin
            pix_next = '0;
        end
        else if (|diff[DIF_W-2:PIX_W+6])
        begin
            pix_next = '1;
        end
        else
        begin
            pix_next = diff[PIX_W+5:6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                sa_valid_reg <= 1'b1;
            end
            else if (sa_adv)
            begin
                sa_valid_reg <= 1'b0;
            end
            if (sa_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pos_reg     <= pos_next;
            neg_reg     <= neg_next;
            sa_meta_reg <= meta;
        end
        if (sa_adv)
        begin
            out_pix_reg  <= pix_next;
            out_meta_reg <= sa_meta_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.sharp_pixel = out_pix_reg;
    assign results.out_row     = out_meta_reg.row;
    assign results.out_col     = out_meta_reg.col;
    assign results.frame_end   = out_meta_reg.frame_end;

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shp_pkg::*;

    localparam int IDLE_PCT    = 24;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        shp_meta_t        meta;
    } sharp_word_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             fs;
        bit               drain;
    } pixel_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    shp_cfg_if cfg_if ();
    shp_pix_if pix_if ();
    shp_res_if res_if ();

    sharpen_3x3_filter_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .pixels  (pix_if),
        .results (res_if)
    );

    // filter state as the block should hold it
    logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
    logic [CFG_W-1:0] gain_reg   = GAIN_EIGHTHS_RST;
    logic [PIX_W-1:0] store_upper [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] store_lower [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [6];
    int unsigned      row_pos;
    int unsigned      col_pos;

    sharp_word_t  sharp_expected [$];
    pixel_word_t  pixel_queue [$];
    int unsigned  pixels_issued;
    int unsigned  pixels_taken;
    int unsigned  idle_pct = IDLE_PCT;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        int unsigned vx;
        vx = 32'(v);
        if (vx < MIN_DIM)
            return MIN_DIM;
        if (vx > maxv)
            return maxv;
        return vx;
    endfunction

    function automatic void wrap_position(input int unsigned w, input int unsigned h);
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
    endfunction

    task automatic apply_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] middle;
        int               g;
        int               centre;
        int               neigh;
        int               acc;
        sharp_word_t      word;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        wrap_position(w, h);
        r = row_pos;
        c = col_pos;
        above  = store_upper[c];
        middle = store_lower[c];
        if (r >= 2 && c >= 2)
        begin
            // sum in 1/64 units: 8*(k8+8)*centre - k8*neighbours
            g      = int'(gain_reg);
            centre = int'(win[3]);
            neigh  = int'(win[0]) + int'(win[1]) + int'(above) + int'(win[2])
                   + int'(middle) + int'(win[4]) + int'(win[5]) + int'(pix);
            acc    = 8 * (g + 8) * centre - g * neigh;
            if (acc < 0)
                word.value = '0;
            else if (acc / 64 > 255)
                word.value = '1;
            else
                word.value = PIX_W'(acc / 64);
            word.meta.row       = COORD_W'(r - 1);
            word.meta.col       = COORD_W'(c - 1);
            word.meta.frame_end = (r == h - 1) && (c == w - 1);
            sharp_expected.push_back(word);
        end
        win[0] = win[1];
        win[1] = above;
        win[2] = win[3];
        win[3] = middle;
        win[4] = win[5];
        win[5] = pix;
        store_upper[c] = middle;
        store_lower[c] = pix;
        col_pos = c + 1;
        wrap_position(w, h);
    endtask

    function automatic void compare_field(input string what, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic fs, input bit drain);
        pixel_word_t word;
        word.pix   = pix;
        word.fs    = fs;
        word.drain = drain;
        pixel_queue.push_back(word);
        pixels_issued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = value;
            REG_FRAME_HEIGHT: height_reg = value;
            REG_GAIN_EIGHTHS: gain_reg   = value;
            default:          ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] g);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_GAIN_EIGHTHS, g);
        cfg_if.valid <= 1'b0;
    endtask

    // a pixel may still be inside the pipeline without a result, hence the settle
    task automatic wait_idle();
        while (pixels_taken != pixels_issued || sharp_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pix_if.valid <= 1'b0;
        else
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                apply_pixel(pix_if.pixel_in, pix_if.frame_start);
                pixels_taken++;
            end
            if (!pix_if.valid || pix_if.ready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct
                    && !(pixel_queue[0].drain && sharp_expected.size() != 0))
                begin
                    pix_if.valid       <= 1'b1;
                    pix_if.pixel_in    <= pixel_queue[0].pix;
                    pix_if.frame_start <= pixel_queue[0].fs;
                    pixel_queue.delete(0);
                end
                else
                    pix_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        sharp_word_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (sharp_expected.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %0d at row %0d col %0d",
                             $time, res_if.sharp_pixel, res_if.out_row, res_if.out_col);
                    error_count++;
                end
                else
                begin
                    want = sharp_expected.pop_front();
                    compare_field("sharp_pixel", 32'(want.value), 32'(res_if.sharp_pixel));
                    compare_field("out_row", 32'(want.meta.row), 32'(res_if.out_row));
                    compare_field("out_col", 32'(want.meta.col), 32'(res_if.out_col));
                    compare_field("frame_end", 32'(want.meta.frame_end),
                                  32'(res_if.frame_end));
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned ph;
        int unsigned n;
        int unsigned k;
        int unsigned w_new;
        int unsigned h_new;
        int unsigned g_new;
        int unsigned w_now;
        logic        fs;
        pix_if.valid       = 1'b0;
        pix_if.pixel_in    = '0;
        pix_if.frame_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        for (k = 0; k < MAX_WIDTH_DEF; k++)
        begin
            store_upper[k] = '0;
            store_lower[k] = '0;
        end
        for (k = 0; k < 6; k++)
            win[k] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // single interior pixel at full gain: bright centre saturates, dark centre goes below zero
        configure(8'd3, 8'd3, 8'd255);
        for (k = 0; k < 9; k++)
            queue_pixel((k == 4) ? 8'hFF : 8'h00, k == 0, 1'b0);
        for (k = 0; k < 9; k++)
            queue_pixel((k == 4) ? 8'h00 : 8'hFF, k == 0, 1'b0);
        wait_idle();

        // no gain passes the centre straight through
        configure(8'd3, 8'd3, 8'd0);
        for (k = 0; k < 9; k++)
            queue_pixel(random_pixel(), k == 0, 1'b0);
        w_now = 3;

        for (ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            if (ph == 0)
            begin
                // widest row, height clamped up, no idling for a long run
                w_new = 255;
                h_new = 0;
                g_new = $urandom_range(1, 254);
                n     = 390;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       w_new = $urandom_range(0, 2);
                    1:       w_new = 3;
                    default: w_new = $urandom_range(4, 12);
                endcase
                case ($urandom_range(0, 3))
                    0:       h_new = $urandom_range(0, 2);
                    1:       h_new = $urandom_range(129, 255);
                    default: h_new = $urandom_range(3, 8);
                endcase
                case ($urandom_range(0, 3))
                    0:       g_new = 0;
                    1:       g_new = 255;
                    2:       g_new = 8;
                    default: g_new = $urandom_range(0, 255);
                endcase
                n = $urandom_range(30, 45);
            end
            configure(CFG_W'(w_new), CFG_W'(h_new), CFG_W'(g_new));
            // a wider row mid-frame would read store entries never written
            fs = (clamp_dim(CFG_W'(w_new), MAX_WIDTH_DEF) > w_now) || ($urandom_range(0, 1) == 1);
            w_now = clamp_dim(CFG_W'(w_new), MAX_WIDTH_DEF);
            if (ph == 0)
                idle_pct = 0;
            for (k = 0; k < n; k++)
                queue_pixel(random_pixel(), (k == 0) ? fs : ($urandom_range(0, 63) == 0),
                            ph == 0 && k == 250);
            if (ph == 0)
            begin
                wait (pixels_taken + 200 >= pixels_issued);
                idle_pct = IDLE_PCT;
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
